// ===== rtl/core/c8pd_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the CRC-8 packet deframer.
package c8pd_pkg;

    localparam int unsigned MAX_BODY_DEF = 32;
    localparam int unsigned FIELD_BYTES  = 14;
    localparam int unsigned GOOD_LENGTH  = 15;
    localparam int unsigned TDATA_W      = 128;

    localparam logic [7:0] MARK_START = 8'hDE;
    localparam logic [7:0] MARK_END   = 8'hAD;
    localparam logic [7:0] CRC_POLY   = 8'h07;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_CRC_BAD = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;

    typedef struct packed {
        logic [63:0] data_word;
        logic [15:0] send_delay;
        logic [15:0] spi_delay;
        logic [7:0]  size_byte;
        logic [7:0]  flag_byte;
        logic [7:0]  body_length;
        logic [1:0]  status;
    } t_result;

    function automatic logic [7:0] crc8_add(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/c8pd_parse.sv =====
// Frame state machine, running CRC-8 and field store; forms one result at frame end.
module c8pd_parse
    import c8pd_pkg::*;
#(
    parameter int unsigned MAX_BODY = MAX_BODY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int unsigned CW     = $clog2(MAX_BODY + 1);
    localparam int unsigned FIDX_W = $clog2(FIELD_BYTES);

    localparam logic [1:0] PH_HUNT1 = 2'd0;
    localparam logic [1:0] PH_HUNT2 = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;
    localparam logic [1:0] PH_MARK  = 2'd3;

    logic [1:0]    r_phase, n_phase;
    logic [7:0]    r_crc, n_crc;
    logic [7:0]    r_crc_prev, n_crc_prev;
    logic [7:0]    r_prev, n_prev;
    logic [CW-1:0] r_count, n_count;
    logic [7:0]    r_store [FIELD_BYTES];
    logic          store_we;
    logic          good_len;

    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_crc_prev  = r_crc_prev;
        n_prev      = r_prev;
        n_count     = r_count;
        store_we    = 1'b0;
        o_res_valid = 1'b0;
        case (r_phase)
            PH_HUNT1: begin
                n_phase = (i_byte == MARK_START) ? PH_HUNT2 : PH_HUNT1;
            end
            PH_HUNT2: begin
                if (i_byte == MARK_START) begin
                    n_phase    = PH_BODY;
                    n_crc      = '0;
                    n_crc_prev = '0;
                    n_prev     = '0;
                    n_count    = '0;
                end else begin
                    n_phase = PH_HUNT1;
                end
            end
            PH_BODY: begin
                if (i_byte == MARK_START) begin
                    n_phase = PH_MARK;
                end else if (r_count >= CW'(MAX_BODY)) begin
                    n_phase = PH_HUNT1;
                end else begin
                    store_we   = (r_count < CW'(FIELD_BYTES));
                    n_crc_prev = r_crc;
                    n_crc      = crc8_add(r_crc, i_byte);
                    n_prev     = i_byte;
                    n_count    = r_count + 1'b1;
                end
            end
            PH_MARK: begin
                if (i_byte != MARK_END) begin
                    n_phase = (i_byte == MARK_START) ? PH_HUNT2 : PH_HUNT1;
                end else begin
                    n_phase     = PH_HUNT1;
                    o_res_valid = i_go;
                end
            end
            default: begin
                n_phase = PH_HUNT1;
            end
        endcase
    end

    assign good_len = (r_count == CW'(GOOD_LENGTH));

    always_comb begin
        o_res             = '0;
        o_res.body_length = 8'(r_count);
        if (!good_len) begin
            o_res.status = ST_BAD_LEN;
        end else begin
            o_res.status     = (r_crc_prev == r_prev) ? ST_GOOD : ST_CRC_BAD;
            o_res.flag_byte  = r_store[0];
            o_res.size_byte  = r_store[1];
            o_res.spi_delay  = {r_store[2], r_store[3]};
            o_res.send_delay = {r_store[4], r_store[5]};
            o_res.data_word  = {r_store[6], r_store[7], r_store[8], r_store[9],
                                r_store[10], r_store[11], r_store[12], r_store[13]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT1;
            r_crc      <= '0;
            r_crc_prev <= '0;
            r_prev     <= '0;
            r_count    <= '0;
        end else if (i_go) begin
            r_phase    <= n_phase;
            r_crc      <= n_crc;
            r_crc_prev <= n_crc_prev;
            r_prev     <= n_prev;
            r_count    <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && store_we) begin
            r_store[r_count[FIDX_W-1:0]] <= i_byte;
        end
    end

endmodule

// ===== rtl/core/c8pd_out_reg.sv =====
// Result register that holds one frame result and drives the master-side stream.
module c8pd_out_reg
    import c8pd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  t_result            i_res,
    output logic               o_space,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata
);

    logic    r_valid;
    t_result r_res;

    assign o_space    = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = TDATA_W'(r_res);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== rtl/core/crc8_packet_deframer.sv =====
// Top level of the CRC-8 packet deframer: input register, frame parser and result register.
//
//  channel  direction  tdata fields (lowest bit up)
//  s        in         rx_byte[7:0]
//  m        out        status[1:0], body_length[9:2], flag_byte[17:10], size_byte[25:18],
//                      spi_delay[41:26], send_delay[57:42], data_word[121:58], zero[127:122]
//
// One word is taken per cycle unless the master side stalls; a word waits in the input
// register and its result, if it closes a frame, is held in the result register.
// The input register is freed whenever the result register has room, so a stalled
// master side holds at most one word inside before the slave side stalls.
// Reset clears the control state only; the field bytes need none.
module crc8_packet_deframer
    import c8pd_pkg::*;
#(
    parameter int unsigned MAX_BODY = MAX_BODY_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [7:0]         i_s_tdata,  // rx_byte[7:0]
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata   // status, body_length, flag_byte, size_byte,
                                           // spi_delay, send_delay, data_word, zero padding
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       space;
    logic       go;
    logic       res_valid;
    t_result    res;

    assign go         = r_in_valid && space;
    assign o_s_tready = !r_in_valid || space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    c8pd_parse #(
        .MAX_BODY (MAX_BODY)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    c8pd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_space     (space),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

endmodule
